FILE: src/bounded_bag_store_assert.svh
// Assertion macros shared by the bounded bag store RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef BOUNDED_BAG_STORE_ASSERT_SVH
`define BOUNDED_BAG_STORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BBS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bounded bag store: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bounded bag store: next-cycle check failed");

`endif

FILE: src/bbs_pkg.sv
// Types and constants of the bounded bag store.
// No dependencies; imported by the top level.
package bbs_pkg;

    localparam int VALUE_W = 32;
    localparam int FIELD_W = 7;

    localparam logic [FIELD_W-1:0] NO_POSITION  = 7'h7F;
    localparam logic [FIELD_W-1:0] CAP_RESET    = 7'd64;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_FIND   = 2'd1,
        OP_REMOVE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT,
        ST_RESP
    } state_t;

endpackage

FILE: src/bounded_bag_store.sv
// Bounded bag store: add, find and remove of 32-bit values kept in insertion order.
// Add, an unused op, or find/remove on an empty bag go straight to the response state;
// find searches the entries in order from index 0; remove then moves each later entry down one place.
// Search and shift are paced by the single entry memory read port, and a new request
// is accepted only once the previous result has been handed to the output register.
// Reset (rst_n, async low) empties the bag and sets capacity to 64; memory is not cleared.
module bounded_bag_store
    import bbs_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,

    // Configuration: capacity register
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,

    // Request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value (signed)
    input  logic [1:0]  s_axis_tuser,   // [1:0] op

    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [6:0] position (signed), [13:7] count, [15:14] zero
    output logic        m_axis_tuser    // [0] success
);

    // Address, count and widened comparison widths
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = CW + 1;
    localparam int XW = (CW > FIELD_W) ? CW : FIELD_W;

    state_t               state_reg, state_next;
    op_t                  op_reg, op_next;
    logic [VALUE_W-1:0]   value_reg, value_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic [CW-1:0]        held_reg, held_next;
    logic [FIELD_W-1:0]   cap_reg;
    logic                 res_success_reg, res_success_next;
    logic [FIELD_W-1:0]   res_pos_reg, res_pos_next;

    logic                 out_valid_reg;
    logic                 out_success_reg;
    logic [FIELD_W-1:0]   out_pos_reg;
    logic [FIELD_W-1:0]   out_count_reg;
    logic                 load_out;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [VALUE_W-1:0]   ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [VALUE_W-1:0]   ram_rdata;

    logic                 s_accept;
    logic                 m_accept;
    logic                 room;
    logic [IW-1:0]        idx_p1;
    logic [IW-1:0]        idx_p2;
    logic [IW-1:0]        held_ext;
    logic [XW-1:0]        held_x;
    logic [XW-1:0]        idx_x;

    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign m_accept = out_valid_reg && m_axis_tready;

    assign idx_p1   = IW'(idx_reg) + IW'(1);
    assign idx_p2   = IW'(idx_reg) + IW'(2);
    assign held_ext = IW'(held_reg);
    assign held_x   = XW'(held_reg);
    assign idx_x    = XW'(idx_reg);

    // Room to append: below the programmed capacity and below the store depth
    assign room = (held_x < XW'(cap_reg)) && (held_reg < CW'(DEPTH));

    // Entry store: one write and one registered read per cycle
    bbs_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequencer: the search walks one entry per cycle with the next read already
    // in flight; the shift moves entry i+1 to i while entry i+2 is being read,
    // so read and write never touch the same entry in one cycle.
    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        value_next       = value_reg;
        idx_next         = idx_reg;
        held_next        = held_reg;
        res_success_next = res_success_reg;
        res_pos_next     = res_pos_reg;
        ram_we           = 1'b0;
        ram_waddr        = held_reg[AW-1:0];
        ram_wdata        = s_axis_tdata;
        ram_raddr        = '0;
        s_axis_tready    = 1'b0;
        load_out         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                // Keep entry 0 on the read port so a search starts at once
                s_axis_tready = 1'b1;
                if (s_accept)
                begin
                    op_next          = op_t'(s_axis_tuser);
                    value_next       = s_axis_tdata;
                    idx_next         = '0;
                    res_success_next = 1'b0;
                    res_pos_next     = NO_POSITION;
                    state_next       = ST_RESP;
                    case (s_axis_tuser) inside
                        OP_ADD:
                        begin
                            if (room)
                            begin
                                // Append at the current count
                                ram_we           = 1'b1;
                                held_next        = held_reg + CW'(1);
                                res_success_next = 1'b1;
                                res_pos_next     = held_x[FIELD_W-1:0];
                            end
                        end
                        OP_FIND, OP_REMOVE:
                        begin
                            if (held_reg != '0)
                            begin
                                state_next = ST_SEARCH;
                            end
                        end
                        default:
                        begin
                            // Unused code: report a miss, change nothing
                        end
                    endcase
                end
            end

            ST_SEARCH:
            begin
                ram_raddr = idx_p1[AW-1:0];
                if (ram_rdata == value_reg)
                begin
                    res_success_next = 1'b1;
                    res_pos_next     = idx_x[FIELD_W-1:0];
                    if (op_reg == OP_REMOVE)
                    begin
                        if (idx_p1 < held_ext)
                        begin
                            state_next = ST_SHIFT;
                        end
                        else
                        begin
                            // Last entry taken: nothing to move down
                            held_next  = held_reg - CW'(1);
                            state_next = ST_RESP;
                        end
                    end
                    else
                    begin
                        state_next = ST_RESP;
                    end
                end
                else if (idx_p1 < held_ext)
                begin
                    idx_next = idx_reg + AW'(1);
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end

            ST_SHIFT:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = ram_rdata;
                ram_raddr = idx_p2[AW-1:0];
                if (idx_p2 < held_ext)
                begin
                    idx_next = idx_reg + AW'(1);
                end
                else
                begin
                    held_next  = held_reg - CW'(1);
                    state_next = ST_RESP;
                end
            end

            ST_RESP:
            begin
                // Hand over once the output register is free or being drained
                if (!out_valid_reg || m_axis_tready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            held_reg  <= '0;
            cap_reg   <= CAP_RESET;
        end
        else
        begin
            state_reg <= state_next;
            held_reg  <= held_next;
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    // Working payload of the transaction in progress
    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        value_reg       <= value_next;
        idx_reg         <= idx_next;
        res_success_reg <= res_success_next;
        res_pos_reg     <= res_pos_next;
    end

    // Output register: hold a result until the downstream side takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_accept)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_success_reg <= res_success_reg;
            out_pos_reg     <= res_pos_reg;
            out_count_reg   <= held_x[FIELD_W-1:0];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_success_reg;
    assign m_axis_tdata  = {2'b00, out_count_reg, out_pos_reg};

`include "bounded_bag_store_assert.svh"

    // The count never passes the store depth
    `BBS_ASSERT_NOW(a_held_bound, clk, rst_n, 1'b1, held_reg <= CW'(DEPTH))

    // A shift only writes inside the held region
    `BBS_ASSERT_NOW(a_shift_in_range, clk, rst_n, state_reg == ST_SHIFT, idx_p1 < held_ext)

    // An accepted add with room grows the count by one
    `BBS_ASSERT_NEXT(a_add_grows, clk, rst_n,
        s_accept && (s_axis_tuser == OP_ADD) && room,
        held_reg == $past(held_reg) + CW'(1))

    // The end of a shift shrinks the count by one
    `BBS_ASSERT_NEXT(a_shift_shrinks, clk, rst_n,
        (state_reg == ST_SHIFT) && !(idx_p2 < held_ext),
        held_reg == $past(held_reg) - CW'(1))

    // A result is loaded only when the output register can take it
    `BBS_ASSERT_NOW(a_no_overwrite, clk, rst_n, load_out, !out_valid_reg || m_axis_tready)

endmodule

FILE: src/bbs_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
